FILE: hdl/sabc_pkg.sv
// Shared types and codes for the scaled alpha blit compositor.
`timescale 1ns / 1ps
package sabc_pkg;
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_COMP  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   localparam logic [2:0] CSR_DEST_X    = 3'd0;
   localparam logic [2:0] CSR_DEST_Y    = 3'd1;
   localparam logic [2:0] CSR_DEST_W    = 3'd2;
   localparam logic [2:0] CSR_DEST_H    = 3'd3;
   localparam logic [2:0] CSR_SRC_W     = 3'd4;
   localparam logic [2:0] CSR_SRC_H     = 3'd5;
   localparam logic [2:0] CSR_SRC_ALPHA = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic        in_range;
      logic [17:0] index;
      logic [31:0] rgba;
   } cmd_type;

   typedef struct packed {
      logic [7:0] dest_x;
      logic [7:0] dest_y;
      logic [8:0] dest_width;
      logic [8:0] dest_height;
      logic [9:0] src_width;
      logic [9:0] src_height;
      logic       src_has_alpha;
   } cfg_type;

   typedef struct packed {
      logic        strobe;
      logic [1:0]  status;
      logic [31:0] rgba;
      logic [16:0] count;
   } rsp_type;
endpackage

FILE: hdl/sabc_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module sabc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/sabc_div.sv
// Restoring divider, one quotient bit per cycle, for the rectangle scale steps.
`timescale 1ns / 1ps
module sabc_div (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [9:0] numer,
   input  logic [8:0] denom,
   output logic       done,
   output logic [9:0] quot,
   output logic [8:0] rem
);
   logic       active_ff, active_in;
   logic       done_ff, done_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [9:0] num_ff, num_in;
   logic [9:0] quot_ff, quot_in;
   logic [8:0] rem_ff, rem_in;
   logic [8:0] den_ff, den_in;
   logic [9:0] shifted;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      shifted   = {rem_ff, num_ff[9]};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 4'd0;
         num_in    = numer;
         den_in    = denom;
         rem_in    = 9'd0;
         quot_in   = 10'd0;
      end else if (active_ff) begin
         num_in = {num_ff[8:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = 9'(shifted - {1'b0, den_ff});
            quot_in = {quot_ff[8:0], 1'b1};
         end else begin
            rem_in  = shifted[8:0];
            quot_in = {quot_ff[8:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd9) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= 4'd0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;
endmodule

FILE: hdl/sabc_front.sv
// Front end: takes requests, range-checks the index and queues them.
`timescale 1ns / 1ps
module sabc_front #(
   parameter int ATLAS_SIDE   = 256,
   parameter int SRC_EDGE_MAX = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             hold,
   output logic             busy,
   input  logic [1:0]       req_type,
   input  logic [17:0]      req_pixel_index,
   input  logic [31:0]      req_pixel_rgba,
   input  logic             pop,
   output logic             head_valid,
   output sabc_pkg::cmd_type head
);
   import sabc_pkg::*;

   localparam int ATLAS_WORDS = ATLAS_SIDE * ATLAS_SIDE;
   localparam int SRC_WORDS   = SRC_EDGE_MAX * SRC_EDGE_MAX;

   cmd_type     queue_ff [4];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff;
   logic        push;
   logic        take;
   logic [23:0] idx_wide;
   cmd_type     cmd;

   assign busy       = (count_ff == 3'd4) || hold;
   assign push       = start && !busy;
   assign head_valid = (count_ff != 3'd0);
   assign take       = pop && head_valid;
   assign head       = queue_ff[rd_ptr_ff];
   assign idx_wide   = {6'd0, req_pixel_index};

   always_comb begin
      cmd.kind  = req_type;
      cmd.index = req_pixel_index;
      cmd.rgba  = req_pixel_rgba;
      case (req_type)
         REQ_LOAD: cmd.in_range = idx_wide < 24'(SRC_WORDS);
         REQ_READ: cmd.in_range = idx_wide < 24'(ATLAS_WORDS);
         default:  cmd.in_range = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + {2'd0, push} - {2'd0, take};
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end
endmodule

FILE: hdl/sabc_back.sv
// Back end: executes loads, reads, clears and composite runs on the two stores.
`timescale 1ns / 1ps
module sabc_back #(
   parameter int ATLAS_SIDE   = 256,
   parameter int SRC_EDGE_MAX = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sabc_pkg::cfg_type                    cfg,
   input  logic                                 head_valid,
   input  sabc_pkg::cmd_type                    head,
   output logic                                 pop,
   output logic                                 init_busy,
   output logic                                 src_we,
   output logic [2*$clog2(SRC_EDGE_MAX)-1:0]    src_waddr,
   output logic [31:0]                          src_wdata,
   output logic [2*$clog2(SRC_EDGE_MAX)-1:0]    src_raddr,
   input  logic [31:0]                          src_rdata,
   output logic                                 atl_we,
   output logic [2*$clog2(ATLAS_SIDE)-1:0]      atl_waddr,
   output logic [31:0]                          atl_wdata,
   output logic [2*$clog2(ATLAS_SIDE)-1:0]      atl_raddr,
   input  logic [31:0]                          atl_rdata,
   output sabc_pkg::rsp_type                    rsp
);
   import sabc_pkg::*;

   localparam int LA  = $clog2(ATLAS_SIDE);
   localparam int AAW = 2 * LA;
   localparam int SAW = 2 * $clog2(SRC_EDGE_MAX);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_CLR  = 4'd2;
   localparam logic [3:0] S_CHK  = 4'd3;
   localparam logic [3:0] S_DIVX = 4'd4;
   localparam logic [3:0] S_DIVY = 4'd5;
   localparam logic [3:0] S_MUL  = 4'd6;
   localparam logic [3:0] S_SEL  = 4'd7;
   localparam logic [3:0] S_ADDR = 4'd8;
   localparam logic [3:0] S_SRD  = 4'd9;
   localparam logic [3:0] S_SDAT = 4'd10;
   localparam logic [3:0] S_ADAT = 4'd11;
   localparam logic [3:0] S_WR   = 4'd12;
   localparam logic [3:0] S_NEXT = 4'd13;

   function automatic logic [7:0] blend(input logic [7:0] d, input logic [7:0] s,
                                        input logic [7:0] a);
      logic [15:0] p_dst;
      logic [15:0] p_src;
      logic [15:0] sum;
      p_dst = {8'd0, 8'd255 - a} * {8'd0, d};
      p_src = {8'd0, a} * {8'd0, s};
      sum   = p_dst + p_src;
      return sum[15:8];
   endfunction

   logic [3:0]     state_ff, state_in;
   logic [AAW-1:0] clr_ff, clr_in;
   logic           rd_pend_ff, rd_pend_in;
   logic           rd_ok_ff, rd_ok_in;
   rsp_type        rsp_ff, rsp_in;
   logic           full_ff, full_in;
   logic [9:0]     qx_ff, qx_in, qy_ff, qy_in;
   logic [8:0]     rx0_ff, rx0_in, ry0_ff, ry0_in;
   logic [8:0]     x_ff, x_in, y_ff, y_in;
   logic [9:0]     sxa_ff, sxa_in, sya_ff, sya_in;
   logic [8:0]     rxa_ff, rxa_in, rya_ff, rya_in;
   logic [19:0]    prodx_ff, prodx_in, prody_ff, prody_in;
   logic [AAW-1:0] dst_ff, dst_in;
   logic [9:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic [SAW-1:0] saddr_ff, saddr_in;
   logic [31:0]    texel_ff, texel_in;
   logic [31:0]    wdata_ff, wdata_in;
   logic [16:0]    count_ff, count_in;

   logic           div_start, div_done;
   logic [9:0]     div_numer, div_quot;
   logic [8:0]     div_denom, div_rem;
   logic [23:0]    idx_wide;
   logic [9:0]     col, row;
   logic [19:0]    sxv, syv, limx, limy;
   logic [19:0]    lin_prod;
   logic [21:0]    lin;
   logic [9:0]     rx_sum, ry_sum;
   logic           skip;

   sabc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign idx_wide  = {6'd0, head.index};
   assign init_busy = (state_ff == S_INIT);
   assign src_waddr = idx_wide[SAW-1:0];
   assign src_wdata = head.rgba;
   assign src_raddr = saddr_ff;
   assign atl_raddr = (state_ff == S_IDLE) ? idx_wide[AAW-1:0] : dst_ff;
   assign rsp       = rsp_ff;

   assign col      = 10'(cfg.dest_x) + 10'(x_ff);
   assign row      = 10'(cfg.dest_y) + 10'(y_ff);
   assign sxv      = full_ff ? (prodx_ff >> LA) : 20'(sxa_ff);
   assign syv      = full_ff ? (prody_ff >> LA) : 20'(sya_ff);
   assign limx     = 20'(cfg.src_width) - 20'd1;
   assign limy     = 20'(cfg.src_height) - 20'd1;
   assign lin_prod = sy_ff * cfg.src_width;
   assign lin      = {2'd0, lin_prod} + {12'd0, sx_ff};
   assign rx_sum   = {1'b0, rxa_ff} + {1'b0, rx0_ff};
   assign ry_sum   = {1'b0, rya_ff} + {1'b0, ry0_ff};

   assign skip = (cfg.src_width == 10'd0) || (cfg.src_height == 10'd0) ||
                 (32'(cfg.src_width) > 32'(SRC_EDGE_MAX)) ||
                 (32'(cfg.src_height) > 32'(SRC_EDGE_MAX)) ||
                 (cfg.dest_width == 9'd0) || (cfg.dest_height == 9'd0) ||
                 (32'(cfg.dest_x) + 32'(cfg.dest_width) > 32'(ATLAS_SIDE)) ||
                 (32'(cfg.dest_y) + 32'(cfg.dest_height) > 32'(ATLAS_SIDE));

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      rd_pend_in = 1'b0;
      rd_ok_in   = rd_ok_ff;
      rsp_in     = rsp_ff;
      rsp_in.strobe = 1'b0;
      full_in    = full_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      rx0_in     = rx0_ff;
      ry0_in     = ry0_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      sxa_in     = sxa_ff;
      sya_in     = sya_ff;
      rxa_in     = rxa_ff;
      rya_in     = rya_ff;
      prodx_in   = prodx_ff;
      prody_in   = prody_ff;
      dst_in     = dst_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      saddr_in   = saddr_ff;
      texel_in   = texel_ff;
      wdata_in   = wdata_ff;
      count_in   = count_ff;
      pop        = 1'b0;
      src_we     = 1'b0;
      atl_we     = 1'b0;
      atl_waddr  = dst_ff;
      atl_wdata  = wdata_ff;
      div_start  = 1'b0;
      div_numer  = cfg.src_width;
      div_denom  = cfg.dest_width;

      // read data comes back in the cycle after the address
      if (rd_pend_ff) begin
         rsp_in.strobe = 1'b1;
         rsp_in.status = ST_READ;
         rsp_in.rgba   = rd_ok_ff ? atl_rdata : 32'd0;
         rsp_in.count  = 17'd0;
      end

      case (state_ff)
         S_INIT, S_CLR: begin
            atl_we    = 1'b1;
            atl_waddr = clr_ff;
            atl_wdata = 32'd0;
            clr_in    = clr_ff + AAW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               case (head.kind)
                  REQ_LOAD: src_we = head.in_range;
                  REQ_COMP: state_in = S_CHK;
                  REQ_READ: begin
                     rd_pend_in = 1'b1;
                     rd_ok_in   = head.in_range;
                  end
                  default: begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
               endcase
            end
         end
         S_CHK: begin
            if (skip) begin
               rsp_in.strobe = 1'b1;
               rsp_in.status = ST_SKIP;
               rsp_in.rgba   = 32'd0;
               rsp_in.count  = 17'd0;
               state_in      = S_IDLE;
            end else begin
               full_in   = (32'(cfg.src_width) >= 32'(ATLAS_SIDE)) &&
                           (32'(cfg.src_height) >= 32'(ATLAS_SIDE));
               div_start = 1'b1;
               state_in  = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_done) begin
               qx_in     = div_quot;
               rx0_in    = div_rem;
               div_start = 1'b1;
               div_numer = cfg.src_height;
               div_denom = cfg.dest_height;
               state_in  = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_done) begin
               qy_in    = div_quot;
               ry0_in   = div_rem;
               x_in     = 9'd0;
               y_in     = 9'd0;
               sxa_in   = 10'd0;
               sya_in   = 10'd0;
               rxa_in   = 9'd0;
               rya_in   = 9'd0;
               count_in = 17'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prodx_in = col * cfg.src_width;
            prody_in = row * cfg.src_height;
            dst_in   = {row[LA-1:0], col[LA-1:0]};
            state_in = S_SEL;
         end
         S_SEL: begin
            sx_in    = (sxv > limx) ? limx[9:0] : sxv[9:0];
            sy_in    = (syv > limy) ? limy[9:0] : syv[9:0];
            state_in = S_ADDR;
         end
         S_ADDR: begin
            saddr_in = lin[SAW-1:0];
            state_in = S_SRD;
         end
         S_SRD: begin
            state_in = S_SDAT;
         end
         S_SDAT: begin
            texel_in = src_rdata;
            // drop fully transparent texels
            state_in = (src_rdata[31:24] == 8'd0) ? S_NEXT : S_ADAT;
         end
         S_ADAT: begin
            if (cfg.src_has_alpha) begin
               wdata_in = {8'hFF,
                           blend(atl_rdata[23:16], texel_ff[23:16], texel_ff[31:24]),
                           blend(atl_rdata[15:8], texel_ff[15:8], texel_ff[31:24]),
                           blend(atl_rdata[7:0], texel_ff[7:0], texel_ff[31:24])};
            end else begin
               wdata_in = {8'hFF, texel_ff[23:0]};
            end
            state_in = S_WR;
         end
         S_WR: begin
            atl_we   = 1'b1;
            count_in = count_ff + 17'd1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            state_in = S_MUL;
            if (x_ff == 9'(cfg.dest_width - 9'd1)) begin
               x_in   = 9'd0;
               sxa_in = 10'd0;
               rxa_in = 9'd0;
               if (y_ff == 9'(cfg.dest_height - 9'd1)) begin
                  rsp_in.strobe = 1'b1;
                  rsp_in.status = ST_DONE;
                  rsp_in.rgba   = 32'd0;
                  rsp_in.count  = count_ff;
                  state_in      = S_IDLE;
               end else begin
                  y_in = y_ff + 9'd1;
                  if (ry_sum >= {1'b0, cfg.dest_height}) begin
                     rya_in = 9'(ry_sum - {1'b0, cfg.dest_height});
                     sya_in = sya_ff + qy_ff + 10'd1;
                  end else begin
                     rya_in = ry_sum[8:0];
                     sya_in = sya_ff + qy_ff;
                  end
               end
            end else begin
               x_in = x_ff + 9'd1;
               // step the column quotient and carry the remainder
               if (rx_sum >= {1'b0, cfg.dest_width}) begin
                  rxa_in = 9'(rx_sum - {1'b0, cfg.dest_width});
                  sxa_in = sxa_ff + qx_ff + 10'd1;
               end else begin
                  rxa_in = rx_sum[8:0];
                  sxa_in = sxa_ff + qx_ff;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         clr_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_ff.strobe <= rsp_in.strobe;
      end
      rsp_ff.status <= rsp_in.status;
      rsp_ff.rgba   <= rsp_in.rgba;
      rsp_ff.count  <= rsp_in.count;
      rd_ok_ff <= rd_ok_in;
      full_ff  <= full_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      rx0_ff   <= rx0_in;
      ry0_ff   <= ry0_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      sxa_ff   <= sxa_in;
      sya_ff   <= sya_in;
      rxa_ff   <= rxa_in;
      rya_ff   <= rya_in;
      prodx_ff <= prodx_in;
      prody_ff <= prody_in;
      dst_ff   <= dst_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      saddr_ff <= saddr_in;
      texel_ff <= texel_in;
      wdata_ff <= wdata_in;
      count_ff <= count_in;
   end
endmodule

FILE: hdl/scaled_alpha_blit_compositor.sv
// Top level of the scaled alpha blit compositor: registers, queue, engine, stores.
//
//  channel   ports                                        handshake
//  request   start, busy, req_type, req_pixel_index/rgba  start && !busy
//  response  rsp_strobe, rsp_status/read_rgba/pixels_...  one-cycle strobe
//  config    csr_write_enable, csr_index, csr_write_data  write enable
//
// Loads leave the four-entry queue one per cycle when the engine is idle, written
// as popped; a read answers via the read-pending flag and the response register.
// A composite run sets up with two 10-step divides, then takes each pixel through
// MUL, SEL, ADDR, SRD, SDAT, ADAT, WR and NEXT, or from SDAT to NEXT for a
// fully transparent texel. A clear and the reset pass write ATLAS_SIDE*ATLAS_SIDE
// words, one word a cycle; busy stays high during the reset pass.
// Responses cannot be stalled; busy rises when the queue is full.
`timescale 1ns / 1ps
module scaled_alpha_blit_compositor #(
   parameter int ATLAS_SIDE   = 256,
   parameter int SRC_EDGE_MAX = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [17:0] req_pixel_index,
   input  logic [31:0] req_pixel_rgba,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_rgba,
   output logic [16:0] rsp_pixels_written,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_write_data
);
   import sabc_pkg::*;

   localparam int AAW = 2 * $clog2(ATLAS_SIDE);
   localparam int SAW = 2 * $clog2(SRC_EDGE_MAX);

   cfg_type        cfg_ff, cfg_in;
   cmd_type        head;
   rsp_type        rsp;
   logic           head_valid, pop, init_busy;
   logic           src_we, atl_we;
   logic [SAW-1:0] src_waddr, src_raddr;
   logic [AAW-1:0] atl_waddr, atl_raddr;
   logic [31:0]    src_wdata, src_rdata, atl_wdata, atl_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEST_X:    cfg_in.dest_x        = csr_write_data[7:0];
            CSR_DEST_Y:    cfg_in.dest_y        = csr_write_data[7:0];
            CSR_DEST_W:    cfg_in.dest_width    = csr_write_data[8:0];
            CSR_DEST_H:    cfg_in.dest_height   = csr_write_data[8:0];
            CSR_SRC_W:     cfg_in.src_width     = csr_write_data;
            CSR_SRC_H:     cfg_in.src_height    = csr_write_data;
            CSR_SRC_ALPHA: cfg_in.src_has_alpha = csr_write_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sabc_front #(.ATLAS_SIDE(ATLAS_SIDE), .SRC_EDGE_MAX(SRC_EDGE_MAX)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .hold            (init_busy),
      .busy            (busy),
      .req_type        (req_type),
      .req_pixel_index (req_pixel_index),
      .req_pixel_rgba  (req_pixel_rgba),
      .pop             (pop),
      .head_valid      (head_valid),
      .head            (head)
   );

   sabc_back #(.ATLAS_SIDE(ATLAS_SIDE), .SRC_EDGE_MAX(SRC_EDGE_MAX)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .init_busy  (init_busy),
      .src_we     (src_we),
      .src_waddr  (src_waddr),
      .src_wdata  (src_wdata),
      .src_raddr  (src_raddr),
      .src_rdata  (src_rdata),
      .atl_we     (atl_we),
      .atl_waddr  (atl_waddr),
      .atl_wdata  (atl_wdata),
      .atl_raddr  (atl_raddr),
      .atl_rdata  (atl_rdata),
      .rsp        (rsp)
   );

   sabc_ram #(.WIDTH(32), .DEPTH(SRC_EDGE_MAX * SRC_EDGE_MAX)) u_src_ram (
      .clock (clock),
      .we    (src_we),
      .waddr (src_waddr),
      .wdata (src_wdata),
      .raddr (src_raddr),
      .rdata (src_rdata)
   );

   sabc_ram #(.WIDTH(32), .DEPTH(ATLAS_SIDE * ATLAS_SIDE)) u_atlas_ram (
      .clock (clock),
      .we    (atl_we),
      .waddr (atl_waddr),
      .wdata (atl_wdata),
      .raddr (atl_raddr),
      .rdata (atl_rdata)
   );

   assign rsp_strobe         = rsp.strobe;
   assign rsp_status         = rsp.status;
   assign rsp_read_rgba      = rsp.rgba;
   assign rsp_pixels_written = rsp.count;
endmodule

FILE: hdl/sabc_checker.sv
// Port-level checks for the compositor, bound to the top level.
`timescale 1ns / 1ps
module sabc_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_read_rgba,
   input logic [16:0] rsp_pixels_written
);
   import sabc_pkg::*;

   // the atlas clearing pass holds off requests right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("busy low right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_DONE || rsp_status == ST_SKIP ||
                      rsp_status == ST_READ))
      else $error("bad response status");

   a_skip_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_SKIP |->
         rsp_read_rgba == 32'd0 && rsp_pixels_written == 17'd0)
      else $error("skipped run carries data");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_READ |-> rsp_pixels_written == 17'd0)
      else $error("read response carries a pixel count");
endmodule

bind scaled_alpha_blit_compositor sabc_checker u_sabc_checker (.*);

FILE: bench/scaled_alpha_blit_compositor_tb.sv
// Self-checking testbench for the scaled alpha blit compositor.
`timescale 1ns / 1ps
module scaled_alpha_blit_compositor_tb;
   import sabc_pkg::*;

   localparam int ATLAS_SIDE   = 256;
   localparam int SRC_EDGE_MAX = 512;
   localparam int ATLAS_WORDS  = ATLAS_SIDE * ATLAS_SIDE;
   localparam int SRC_WORDS    = SRC_EDGE_MAX * SRC_EDGE_MAX;
   localparam int STALL_LIMIT  = 400000;
   localparam int ITEM_TARGET  = 1250;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] rgba;
      logic [16:0] count;
   } blit_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic [17:0] req_pixel_index;
   logic [31:0] req_pixel_rgba;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_read_rgba;
   logic [16:0] rsp_pixels_written;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [9:0]  csr_write_data;

   // predictor state
   logic [31:0]     atlas_img [ATLAS_WORDS];
   logic [31:0]     source_img [SRC_WORDS];
   bit              source_loaded [SRC_WORDS];
   cfg_type         blit_cfg;
   blit_result_type pending_results[$];

   int  error_count;
   int  items_sent;
   int  stall_cycles;
   bit  no_gaps;

   scaled_alpha_blit_compositor u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_pixel_index(req_pixel_index),
      .req_pixel_rgba(req_pixel_rgba), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_read_rgba(rsp_read_rgba),
      .rsp_pixels_written(rsp_pixels_written),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int sample_index(int x, int y);
      int sx, sy, sw, sh;
      sw = blit_cfg.src_width;
      sh = blit_cfg.src_height;
      if (sw >= ATLAS_SIDE && sh >= ATLAS_SIDE) begin
         sx = ((blit_cfg.dest_x + x) * sw) / ATLAS_SIDE;
         sy = ((blit_cfg.dest_y + y) * sh) / ATLAS_SIDE;
      end else begin
         sx = (x * sw) / blit_cfg.dest_width;
         sy = (y * sh) / blit_cfg.dest_height;
      end
      if (sx > sw - 1) sx = sw - 1;
      if (sy > sh - 1) sy = sh - 1;
      return (sy * sw + sx) % SRC_WORDS;
   endfunction

   function automatic bit rect_skipped();
      return blit_cfg.src_width == 0 || blit_cfg.src_height == 0 ||
             blit_cfg.src_width > SRC_EDGE_MAX || blit_cfg.src_height > SRC_EDGE_MAX ||
             blit_cfg.dest_width == 0 || blit_cfg.dest_height == 0 ||
             int'(blit_cfg.dest_x) + int'(blit_cfg.dest_width) > ATLAS_SIDE ||
             int'(blit_cfg.dest_y) + int'(blit_cfg.dest_height) > ATLAS_SIDE;
   endfunction

   // Walk the rectangle and update the atlas image; returns pixels written.
   function automatic int composite_atlas();
      int          count, didx;
      logic [31:0] texel, d, res;
      logic [7:0]  a;
      count = 0;
      for (int y = 0; y < blit_cfg.dest_height; y++) begin
         for (int x = 0; x < blit_cfg.dest_width; x++) begin
            texel = source_img[sample_index(x, y)];
            a = texel[31:24];
            if (a == 8'd0) continue;
            didx = ((blit_cfg.dest_y + y) * ATLAS_SIDE + blit_cfg.dest_x + x) % ATLAS_WORDS;
            d = atlas_img[didx];
            res = '0;
            if (!blit_cfg.src_has_alpha) begin
               res[23:0] = texel[23:0];
            end else begin
               for (int c = 0; c < 3; c++)
                  res[c*8 +: 8] = 8'((((255 - int'(a)) * int'(d[c*8 +: 8])) +
                                      int'(a) * int'(texel[c*8 +: 8])) >> 8);
            end
            atlas_img[didx] = {8'hFF, res[23:0]};
            count++;
         end
      end
      return count;
   endfunction

   task automatic predict_request(logic [1:0] kind, logic [17:0] index, logic [31:0] rgba);
      blit_result_type r;
      r = '{status: ST_DONE, rgba: '0, count: '0};
      case (kind)
         REQ_LOAD: begin
            source_img[index] = rgba;
            source_loaded[index] = 1'b1;
            return;
         end
         REQ_COMP: begin
            if (rect_skipped()) r.status = ST_SKIP;
            else r.count = 17'(composite_atlas());
         end
         REQ_READ: begin
            r.status = ST_READ;
            if (index < ATLAS_WORDS) r.rgba = atlas_img[index];
         end
         default: begin
            for (int i = 0; i < ATLAS_WORDS; i++) atlas_img[i] = '0;
            return;
         end
      endcase
      pending_results.insert(pending_results.size(), r);
   endtask

   // Called at a falling edge; returns at a falling edge after the request is taken.
   task automatic send_request(logic [1:0] kind, logic [17:0] index, logic [31:0] rgba);
      int gap, pick;
      start           <= 1'b1;
      req_type        <= kind;
      req_pixel_index <= index;
      req_pixel_rgba  <= rgba;
      do @(posedge clock); while (busy);
      predict_request(kind, index, rgba);
      items_sent++;
      @(negedge clock);
      pick = $urandom_range(99);
      if (no_gaps || pick < 50) gap = 0;
      else if (pick < 90) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_results_done();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Read back one word so every queued load and clear has retired, then settle.
   task automatic drain();
      send_request(REQ_READ, 18'($urandom_range(ATLAS_WORDS - 1)), $urandom);
      start <= 1'b0;
      wait_results_done();
      repeat (10) @(negedge clock);
   endtask

   task automatic write_config(cfg_type c);
      logic [9:0] vals [7];
      vals = '{10'(c.dest_x), 10'(c.dest_y), 10'(c.dest_width), 10'(c.dest_height),
               c.src_width, c.src_height, 10'(c.src_has_alpha)};
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= 3'(i);
         csr_write_data   <= vals[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      blit_cfg = c;
   endtask

   function automatic logic [31:0] random_texel();
      int pick;
      logic [31:0] t;
      pick = $urandom_range(9);
      t = $urandom;
      if (pick < 2) t[31:24] = 8'h00;
      else if (pick < 5) t[31:24] = 8'hFF;
      return t;
   endfunction

   // Load each sampled source texel never written before, and reload some at random.
   task automatic load_sampled_texels();
      int idx;
      if (rect_skipped()) return;
      for (int y = 0; y < blit_cfg.dest_height; y++)
         for (int x = 0; x < blit_cfg.dest_width; x++) begin
            idx = sample_index(x, y);
            if (!source_loaded[idx] || $urandom_range(7) == 0)
               send_request(REQ_LOAD, 18'(idx), random_texel());
         end
   endtask

   task automatic read_rect_pixel();
      int x, y;
      x = blit_cfg.dest_x + $urandom_range(blit_cfg.dest_width > 0 ? blit_cfg.dest_width - 1 : 0);
      y = blit_cfg.dest_y + $urandom_range(blit_cfg.dest_height > 0 ? blit_cfg.dest_height - 1 : 0);
      send_request(REQ_READ, 18'((y * ATLAS_SIDE + x) % ATLAS_WORDS), $urandom);
   endtask

   task automatic run_blit(cfg_type c, int reads);
      drain();
      write_config(c);
      load_sampled_texels();
      send_request(REQ_COMP, 18'($urandom), $urandom);
      for (int i = 0; i < reads; i++) read_rect_pixel();
   endtask

   task automatic test_reads_after_reset();
      send_request(REQ_READ, 18'd0, 32'hFFFF_FFFF);
      send_request(REQ_READ, 18'(ATLAS_WORDS - 1), 32'h0);
      send_request(REQ_READ, 18'(ATLAS_WORDS), 32'h0);
      send_request(REQ_READ, 18'h3FFFF, 32'h0);
      send_request(REQ_COMP, 18'h3FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_skipped_runs();
      cfg_type c;
      c = '{dest_x: 8'd255, dest_y: 8'd0, dest_width: 9'd2, dest_height: 9'd1,
            src_width: 10'd4, src_height: 10'd4, src_has_alpha: 1'b0};
      run_blit(c, 0);
      c = '{8'd0, 8'd1, 9'd4, 9'd256, 10'd4, 10'd4, 1'b1};
      run_blit(c, 0);
      c = '{8'd0, 8'd0, 9'd4, 9'd4, 10'd1023, 10'd4, 1'b0};
      run_blit(c, 0);
      c = '{8'd0, 8'd0, 9'd4, 9'd4, 10'd4, 10'd0, 1'b0};
      run_blit(c, 0);
      c = '{8'd0, 8'd0, 9'd0, 9'd4, 10'd4, 10'd4, 1'b0};
      run_blit(c, 0);
      c = '{8'd0, 8'd0, 9'd511, 9'd1, 10'd4, 10'd4, 1'b0};
      run_blit(c, 0);
   endtask

   task automatic test_directed_blits();
      cfg_type c;
      c = '{8'd0, 8'd0, 9'd256, 9'd2, 10'd8, 10'd2, 1'b0};
      run_blit(c, 3);
      c = '{8'd0, 8'd0, 9'd256, 9'd2, 10'd3, 10'd5, 1'b1};
      run_blit(c, 3);
      c = '{8'd255, 8'd0, 9'd1, 9'd256, 10'd1, 10'd1, 1'b1};
      run_blit(c, 2);
      c = '{8'd250, 8'd253, 9'd6, 9'd3, 10'd512, 10'd512, 1'b1};
      run_blit(c, 3);
      c = '{8'd10, 8'd20, 9'd5, 9'd5, 10'd256, 10'd300, 1'b0};
      run_blit(c, 3);
   endtask

   task automatic test_clear();
      send_request(REQ_CLEAR, 18'h3FFFF, 32'hFFFF_FFFF);
      read_rect_pixel();
      drain();
   endtask

   task automatic test_random_blits();
      cfg_type c;
      int      pick, clears, budget;
      clears = 0;
      while (items_sent < ITEM_TARGET) begin
         no_gaps = ($urandom_range(4) == 0);
         pick = $urandom_range(99);
         c.src_has_alpha = 1'($urandom);
         c.dest_width  = 9'($urandom_range(16, 1));
         c.dest_height = 9'($urandom_range(16, 1));
         if (pick < 10) c.dest_width = 9'($urandom_range(256, 64));
         c.dest_x = 8'($urandom_range(ATLAS_SIDE - c.dest_width));
         c.dest_y = 8'($urandom_range(ATLAS_SIDE - c.dest_height));
         if (pick >= 75) begin
            c.src_width  = 10'($urandom_range(SRC_EDGE_MAX, ATLAS_SIDE));
            c.src_height = 10'($urandom_range(SRC_EDGE_MAX, ATLAS_SIDE));
         end else begin
            c.src_width  = 10'($urandom_range(40, 1));
            c.src_height = 10'($urandom_range(300, 1));
         end
         if (pick >= 92) begin
            c.dest_x = 8'($urandom);
            c.dest_width = 9'($urandom);
            c.src_width = 10'($urandom);
         end
         // keep the last runs small so the request total stays near the target
         budget = ITEM_TARGET - items_sent;
         if (int'(c.dest_width) * int'(c.dest_height) > budget + 64) c.dest_height = 9'd1;
         run_blit(c, $urandom_range(4));
         // stray loads and reads between runs
         repeat ($urandom_range(3)) send_request(REQ_LOAD, 18'($urandom), $urandom);
         repeat ($urandom_range(2)) send_request(REQ_READ, 18'($urandom), $urandom);
         if (clears < 2 && $urandom_range(29) == 0) begin
            clears++;
            send_request(REQ_CLEAR, 18'($urandom), $urandom);
         end
         if ($urandom_range(9) == 0) begin
            start <= 1'b0;
            wait_results_done();
         end
         // a repeat composite with the same setup
         if ($urandom_range(3) == 0) send_request(REQ_COMP, 18'($urandom), $urandom);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = REQ_LOAD;
      req_pixel_index  = '0;
      req_pixel_rgba   = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DEST_X;
      csr_write_data   = '0;
      error_count      = 0;
      items_sent       = 0;
      no_gaps          = 1'b0;
      blit_cfg         = '0;
      for (int i = 0; i < ATLAS_WORDS; i++) atlas_img[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reads_after_reset();
      test_skipped_runs();
      test_directed_blits();
      test_clear();
      test_random_blits();
      start <= 1'b0;
      wait_results_done();
      repeat (50) @(negedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      blit_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response status=%0d", rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_read_rgba !== want.rgba) begin
               $error("read_rgba expected %h actual %h", want.rgba, rsp_read_rgba);
               error_count++;
            end
            if (rsp_pixels_written !== want.count) begin
               $error("pixels_written expected %0d actual %0d", want.count,
                      rsp_pixels_written);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run: count cycles with no request taken and no response.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end
endmodule
